>>> src/isc_pkg.sv
// Shared types and constants for the serial programming command decoder.
// Depends on nothing; the RTL modules refer to it by scoped names, the benches import it.
`timescale 1ns / 1ps

package isc_pkg;

  // Result classes
  localparam logic [3:0] EV_ENABLE    = 4'd0;
  localparam logic [3:0] EV_SIG0      = 4'd1;
  localparam logic [3:0] EV_SIG1      = 4'd2;
  localparam logic [3:0] EV_SIG2      = 4'd3;
  localparam logic [3:0] EV_ERASE     = 4'd4;
  localparam logic [3:0] EV_FUSE      = 4'd5;
  localparam logic [3:0] EV_HFUSE     = 4'd6;
  localparam logic [3:0] EV_EFUSE     = 4'd7;
  localparam logic [3:0] EV_LOCK      = 4'd8;
  localparam logic [3:0] EV_EEPROM    = 4'd9;
  localparam logic [3:0] EV_READ_PROG = 4'd10;
  localparam logic [3:0] EV_LOAD_PAGE = 4'd11;
  localparam logic [3:0] EV_WRITE_PG  = 4'd12;
  localparam logic [3:0] EV_WARNING   = 4'd13;
  localparam logic [3:0] EV_DEVICE    = 4'd14;

  // Warning kinds
  localparam logic [1:0] WARN_NONE    = 2'd0;
  localparam logic [1:0] WARN_REPLY   = 2'd1;
  localparam logic [1:0] WARN_VENDOR  = 2'd2;
  localparam logic [1:0] WARN_UNKNOWN = 2'd3;

  // Vendor classes
  localparam logic [1:0] VND_MAIN    = 2'd0;
  localparam logic [1:0] VND_LOCKED  = 2'd1;
  localparam logic [1:0] VND_UNKNOWN = 2'd2;

  // Command and reply byte codes
  localparam logic [7:0] OP_PROG_EN   = 8'hAC;
  localparam logic [7:0] OP_PROG_EN2  = 8'h53;
  localparam logic [7:0] OP_FUSE_RD   = 8'h50;
  localparam logic [7:0] OP_LOCK_RD   = 8'h58;
  localparam logic [7:0] OP_FUSE_SEL  = 8'h08;
  localparam logic [7:0] OP_SIG_RD    = 8'h30;
  localparam logic [7:0] OP_EE_RD     = 8'hA0;
  localparam logic [7:0] OP_PROG_RDL  = 8'h20;
  localparam logic [7:0] OP_PROG_RDH  = 8'h28;
  localparam logic [7:0] OP_LOAD_L    = 8'h40;
  localparam logic [7:0] OP_LOAD_H    = 8'h48;
  localparam logic [7:0] OP_WRITE_PG  = 8'h4C;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] SIG_IDX1     = 8'h01;
  localparam logic [7:0] SIG_IDX2     = 8'h02;
  localparam logic [7:0] VENDOR_MAIN  = 8'h1E;

  // Device table: family byte and part byte per entry
  localparam int DEV_COUNT = 9;
  localparam logic [3:0] DEV_UNKNOWN = 4'd9;
  localparam logic [7:0] DEV_FAMILY [DEV_COUNT] =
    '{8'h90, 8'h91, 8'h92, 8'h92, 8'h93, 8'h93, 8'h94, 8'hFF, 8'h01};
  localparam logic [7:0] DEV_PART [DEV_COUNT] =
    '{8'h01, 8'h01, 8'h01, 8'h05, 8'h01, 8'h0A, 8'h06, 8'hFF, 8'h02};

  // Find the first table entry that matches both bytes
  function automatic logic [3:0] device_lookup(input logic [7:0] fam, input logic [7:0] part);
    logic [3:0] id;
    id = DEV_UNKNOWN;
    for (int i = DEV_COUNT - 1; i >= 0; i--) begin
      if (DEV_FAMILY[i] == fam && DEV_PART[i] == part) id = 4'(i);
    end
    return id;
  endfunction

  // Extra results that follow the main one
  typedef struct packed {
    logic has_dev;
    logic has_w1;
    logic has_w2;
  } isc_extra_t;

  // Decoded command handed from front to back
  typedef struct packed {
    logic [3:0]  cls;
    logic [1:0]  warn;
    logic [7:0]  data;
    logic [11:0] addr;
    logic        hi;
    logic [1:0]  vendor;
    logic [3:0]  dev_id;
    logic [31:0] cmd_word;
    logic [31:0] reply_word;
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] dev_start;
    isc_extra_t  extra;
  } isc_cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } isc_qstat_t;

  // One result item
  typedef struct packed {
    logic [3:0]  event_class;
    logic [1:0]  warning_kind;
    logic [7:0]  data_value;
    logic [11:0] mem_address;
    logic        high_half;
    logic [1:0]  vendor_class;
    logic [3:0]  device_id;
    logic [31:0] command_word;
    logic [31:0] reply_word;
    logic [63:0] span_start;
    logic [63:0] span_end;
    logic        last_of_run;
  } isc_result_t;

endpackage

>>> src/isc_if.sv
// Valid/ready channel interfaces for byte transfers in and results out.
// Uses no package; payload widths follow the field list of the block.
`timescale 1ns / 1ps

interface isc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  host_byte;
  logic [7:0]  target_byte;
  logic [63:0] byte_start_time;
  logic [63:0] byte_end_time;

  modport source (output valid, host_byte, target_byte, byte_start_time, byte_end_time,
                  input ready);
  modport sink (input valid, host_byte, target_byte, byte_start_time, byte_end_time,
                output ready);
endinterface

interface isc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_class;
  logic [1:0]  warning_kind;
  logic [7:0]  data_value;
  logic [11:0] mem_address;
  logic        high_half;
  logic [1:0]  vendor_class;
  logic [3:0]  device_id;
  logic [31:0] command_word;
  logic [31:0] reply_word;
  logic [63:0] span_start;
  logic [63:0] span_end;
  logic        last_of_run;

  modport source (output valid, event_class, warning_kind, data_value, mem_address,
                  high_half, vendor_class, device_id, command_word, reply_word,
                  span_start, span_end, last_of_run, input ready);
  modport sink (input valid, event_class, warning_kind, data_value, mem_address,
                high_half, vendor_class, device_id, command_word, reply_word,
                span_start, span_end, last_of_run, output ready);
endinterface

>>> src/isc_front.sv
// Front end: gathers four transfers into a command, classifies it, tracks signature state.
// Depends on isc_pkg and the isc_in_if interface.
`timescale 1ns / 1ps

module isc_front (
  input  logic                clk,
  input  logic                rst_n,
  isc_in_if.sink              in_ch,
  input  isc_pkg::isc_qstat_t q_stat,
  output logic                push,
  output isc_pkg::isc_cmd_t   cmd
);

  logic [1:0]  pos_r;
  logic [7:0]  host_r [3];
  logic [7:0]  tgt_r  [3];
  logic [63:0] cmd_start_r;
  logic [63:0] dev_start_r;
  logic [7:0]  echo_r, echo_nxt;
  logic [7:0]  poll1_r, poll1_nxt;
  logic [7:0]  poll2_r, poll2_nxt;
  logic [7:0]  fam_r, fam_nxt;
  logic [63:0] dev_start_nxt;
  logic        accept;
  logic        last_byte;
  logic [7:0]  c0, c1, c2, c3, t0, t1, t2, t3;

  assign last_byte   = (pos_r == 2'd3);
  assign in_ch.ready = !last_byte || !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && last_byte;

  assign c0 = host_r[0];
  assign c1 = host_r[1];
  assign c2 = host_r[2];
  assign c3 = in_ch.host_byte;
  assign t0 = tgt_r[0];
  assign t1 = tgt_r[1];
  assign t2 = tgt_r[2];
  assign t3 = in_ch.target_byte;

  // Classify the command on its fourth transfer
  always_comb begin
    cmd            = '0;
    cmd.s0         = cmd_start_r;
    cmd.s1         = in_ch.byte_end_time;
    cmd.dev_start  = dev_start_r;
    echo_nxt       = echo_r;
    poll1_nxt      = poll1_r;
    poll2_nxt      = poll2_r;
    fam_nxt        = fam_r;
    dev_start_nxt  = dev_start_r;
    if (c0 == isc_pkg::OP_PROG_EN && c1 == isc_pkg::OP_PROG_EN2) begin
      cmd.cls          = isc_pkg::EV_ENABLE;
      cmd.extra.has_w1 = t1 != isc_pkg::OP_PROG_EN || t2 != isc_pkg::OP_PROG_EN2 || t3 != c2;
    end else if (c0 == isc_pkg::OP_PROG_EN && c1[7]) begin
      cmd.cls          = isc_pkg::EV_ERASE;
      cmd.extra.has_w1 = t1 != isc_pkg::OP_PROG_EN || !t2[7] || t3 != c2;
    end else if (c0 == isc_pkg::OP_FUSE_RD && c1 == isc_pkg::BYTE_ZERO &&
                 c2 == isc_pkg::BYTE_ZERO) begin
      cmd.cls  = isc_pkg::EV_FUSE;
      cmd.data = t3;
    end else if (c0 == isc_pkg::OP_LOCK_RD && c1 == isc_pkg::OP_FUSE_SEL &&
                 c2 == isc_pkg::BYTE_ZERO) begin
      cmd.cls  = isc_pkg::EV_HFUSE;
      cmd.data = t3;
    end else if (c0 == isc_pkg::OP_FUSE_RD && c1 == isc_pkg::OP_FUSE_SEL &&
                 c2 == isc_pkg::BYTE_ZERO) begin
      cmd.cls  = isc_pkg::EV_EFUSE;
      cmd.data = t3;
    end else if (c0 == isc_pkg::OP_SIG_RD && c2 == isc_pkg::BYTE_ZERO) begin
      cmd.cls  = isc_pkg::EV_SIG0;
      cmd.data = t3;
      if (t3 == isc_pkg::VENDOR_MAIN)    cmd.vendor = isc_pkg::VND_MAIN;
      else if (t3 == isc_pkg::BYTE_ZERO) cmd.vendor = isc_pkg::VND_LOCKED;
      else                               cmd.vendor = isc_pkg::VND_UNKNOWN;
      cmd.extra.has_w1 = t1 != isc_pkg::OP_SIG_RD || t2 != c1;
      cmd.extra.has_w2 = t3 != isc_pkg::VENDOR_MAIN;
      echo_nxt         = c1;
      poll1_nxt        = c3;
    end else if (c0 == isc_pkg::OP_SIG_RD && c2 == isc_pkg::SIG_IDX1) begin
      cmd.cls          = isc_pkg::EV_SIG1;
      cmd.data         = t3;
      cmd.extra.has_w1 = t1 != isc_pkg::OP_SIG_RD || t2 != c1 || t0 != poll1_r;
      fam_nxt          = t3;
      poll2_nxt        = c3;
      dev_start_nxt    = cmd_start_r;
    end else if (c0 == isc_pkg::OP_SIG_RD && c2 == isc_pkg::SIG_IDX2) begin
      cmd.cls           = isc_pkg::EV_SIG2;
      cmd.data          = t3;
      cmd.dev_id        = isc_pkg::device_lookup(fam_r, t3);
      cmd.extra.has_dev = 1'b1;
      cmd.extra.has_w1  = t1 != isc_pkg::OP_SIG_RD || t2 != echo_r || t0 != poll2_r;
      echo_nxt          = isc_pkg::BYTE_ZERO;
      poll1_nxt         = isc_pkg::BYTE_ZERO;
      poll2_nxt         = isc_pkg::BYTE_ZERO;
    end else if (c0 == isc_pkg::OP_LOCK_RD && c1 == isc_pkg::BYTE_ZERO) begin
      cmd.cls  = isc_pkg::EV_LOCK;
      cmd.data = t3;
    end else if (c0 == isc_pkg::OP_EE_RD && c1[7:6] == 2'b00) begin
      cmd.cls  = isc_pkg::EV_EEPROM;
      cmd.data = t3;
      cmd.addr = {3'b000, c1[0], c2};
    end else if ((c0 == isc_pkg::OP_PROG_RDL || c0 == isc_pkg::OP_PROG_RDH) &&
                 c1[7:4] == 4'h0) begin
      cmd.cls  = isc_pkg::EV_READ_PROG;
      cmd.data = t3;
      cmd.addr = {c1[3:0], c2};
      cmd.hi   = c0[3];
    end else if ((c0 == isc_pkg::OP_LOAD_L || c0 == isc_pkg::OP_LOAD_H) &&
                 c1[7:4] == 4'h0) begin
      cmd.cls  = isc_pkg::EV_LOAD_PAGE;
      cmd.data = c3;
      cmd.addr = {7'b0000000, c2[4:0]};
      cmd.hi   = c0[3];
    end else if (c0 == isc_pkg::OP_WRITE_PG && c1[7:4] == 4'h0) begin
      cmd.cls  = isc_pkg::EV_WRITE_PG;
      cmd.addr = {5'b00000, c1[3:0], c2[7:5]};
    end else begin
      cmd.cls        = isc_pkg::EV_WARNING;
      cmd.warn       = isc_pkg::WARN_UNKNOWN;
      cmd.cmd_word   = {c0, c1, c2, c3};
      cmd.reply_word = {t0, t1, t2, t3};
    end
  end

  // Advance the byte position and commit signature state with the command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      cmd_start_r <= '0;
      dev_start_r <= '0;
      echo_r      <= '0;
      poll1_r     <= '0;
      poll2_r     <= '0;
      fam_r       <= '0;
    end else if (accept) begin
      pos_r <= pos_r + 2'd1;
      if (pos_r == 2'd0) cmd_start_r <= in_ch.byte_start_time;
      if (last_byte) begin
        dev_start_r <= dev_start_nxt;
        echo_r      <= echo_nxt;
        poll1_r     <= poll1_nxt;
        poll2_r     <= poll2_nxt;
        fam_r       <= fam_nxt;
      end
    end
  end

  // Hold the first three bytes of the command
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos_r)
        2'd0: begin host_r[0] <= in_ch.host_byte; tgt_r[0] <= in_ch.target_byte; end
        2'd1: begin host_r[1] <= in_ch.host_byte; tgt_r[1] <= in_ch.target_byte; end
        2'd2: begin host_r[2] <= in_ch.host_byte; tgt_r[2] <= in_ch.target_byte; end
        default: ;
      endcase
    end
  end

endmodule

>>> src/isc_queue.sv
// Short queue of decoded commands between front and back.
// Depends on isc_pkg for the command and status types.
`timescale 1ns / 1ps

module isc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  isc_pkg::isc_cmd_t   din,
  input  logic                pop,
  output isc_pkg::isc_cmd_t   dout,
  output isc_pkg::isc_qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  isc_pkg::isc_cmd_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign dout       = slots_r[rd_ptr_r];
  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= din;
  end

endmodule

>>> src/isc_back.sv
// Back end: expands each queued command into its one to three results.
// Depends on isc_pkg and the isc_out_if interface.
`timescale 1ns / 1ps

module isc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  isc_pkg::isc_cmd_t   head,
  input  isc_pkg::isc_qstat_t q_stat,
  output logic                pop,
  isc_out_if.source           out_ch
);

  isc_pkg::isc_result_t out_r, res;
  logic                 out_valid_r;
  logic                 main_done_r;
  isc_pkg::isc_extra_t  pend_r, rem_after;
  logic                 load;
  logic                 last;

  // Pick the next result of the head command
  always_comb begin
    res            = '0;
    res.span_start = head.s0;
    res.span_end   = head.s1;
    rem_after      = pend_r;
    if (!main_done_r) begin
      res.event_class  = head.cls;
      res.warning_kind = head.warn;
      res.data_value   = head.data;
      res.mem_address  = head.addr;
      res.high_half    = head.hi;
      res.vendor_class = head.vendor;
      res.command_word = head.cmd_word;
      res.reply_word   = head.reply_word;
      rem_after        = head.extra;
    end else if (pend_r.has_dev) begin
      res.event_class  = isc_pkg::EV_DEVICE;
      res.device_id    = head.dev_id;
      res.span_start   = head.dev_start;
      rem_after.has_dev = 1'b0;
    end else if (pend_r.has_w1) begin
      res.event_class  = isc_pkg::EV_WARNING;
      res.warning_kind = isc_pkg::WARN_REPLY;
      rem_after.has_w1 = 1'b0;
    end else begin
      res.event_class  = isc_pkg::EV_WARNING;
      res.warning_kind = isc_pkg::WARN_VENDOR;
      rem_after        = '0;
    end
    last            = (rem_after == '0);
    res.last_of_run = last;
  end

  assign load = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign pop  = load && last;

  // Load the output register and step through the command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      main_done_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        main_done_r <= !last;
        pend_r      <= rem_after;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_class  = out_r.event_class;
  assign out_ch.warning_kind = out_r.warning_kind;
  assign out_ch.data_value   = out_r.data_value;
  assign out_ch.mem_address  = out_r.mem_address;
  assign out_ch.high_half    = out_r.high_half;
  assign out_ch.vendor_class = out_r.vendor_class;
  assign out_ch.device_id    = out_r.device_id;
  assign out_ch.command_word = out_r.command_word;
  assign out_ch.reply_word   = out_r.reply_word;
  assign out_ch.span_start   = out_r.span_start;
  assign out_ch.span_end     = out_r.span_end;
  assign out_ch.last_of_run  = out_r.last_of_run;

endmodule

>>> src/isp_spi_command_decoder_top.sv
// Serial programming command decoder, top level: front, command queue, back.
// Depends on isc_pkg, the channel interfaces, isc_front, isc_queue and isc_back.
//
// Usage:
//   in_ch carries one SPI byte transfer per item: host byte, target byte and the
//   start and end sample times. Four transfers form one command.
//   out_ch carries the results: one to three per command, last_of_run set on the
//   final one. The first three transfers of a command produce nothing.
// Timing:
//   A transfer is taken every cycle while in_ch.ready is high. The fourth transfer of a
//   command writes a decoded entry into the queue, and the back then loads its first
//   result into the output register. The output register is the only stage between queue
//   and receiver, so results leave at one per cycle while the receiver holds ready high.
// Stalls:
//   When the receiver holds ready low, the back holds its result and the queue
//   fills; the front keeps taking the first three transfers of the next command
//   and holds off the fourth only while the queue is full.
// Reset:
//   Synchronous, active low; clears byte position, signature state, queue and
//   output valid. No clearing pass is needed.
`timescale 1ns / 1ps

module isp_spi_command_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  isc_in_if.sink    in_ch,
  isc_out_if.source out_ch
);

  isc_pkg::isc_cmd_t   push_cmd, head_cmd;
  isc_pkg::isc_qstat_t q_stat;
  logic                push, pop;

  isc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  isc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .stat  (q_stat)
  );

  isc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // Never write a full queue unless it is also popped
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop)
    else $error("command queue overflow");

  // Never read an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command queue underflow");

  // A taken result that is not the last of its command is followed at once
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |=> out_ch.valid)
    else $error("result run broken");
`endif

endmodule

>>> tb/sv/isp_command_checker.sv
// Scoreboard for the serial programming command decoder: watches both channels,
// predicts the results of every command and compares them field by field.
// Depends on isc_pkg and the channel interfaces in isc_if.sv.
`timescale 1ns / 1ps

module isp_command_checker (
  input  logic clk,
  input  logic rst_n,
  isc_in_if    in_ch,
  isc_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_events
);
  import isc_pkg::*;

  // Decoder state as seen by the predictor
  logic [1:0]  byte_slot;
  logic [7:0]  host_seen [3];
  logic [7:0]  reply_seen [3];
  logic [63:0] command_t0;
  logic [63:0] command_t1;
  logic [63:0] device_t0;
  logic [7:0]  echo_addr;
  logic [7:0]  poll_first;
  logic [7:0]  poll_second;
  logic [7:0]  family_id;

  // Results of the command being decoded, then the queue of expected results
  isc_result_t batch [3];
  int          batch_len;
  isc_result_t expected_events [$];
  isc_result_t head_event;

  // Print one line per mismatch (bounded) and count all of them
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Device table lookup, first match wins
  function automatic logic [3:0] find_device(input logic [7:0] fam, input logic [7:0] part);
    case ({fam, part})
      16'h9001: return 4'd0;
      16'h9101: return 4'd1;
      16'h9201: return 4'd2;
      16'h9205: return 4'd3;
      16'h9301: return 4'd4;
      16'h930A: return 4'd5;
      16'h9406: return 4'd6;
      16'hFFFF: return 4'd7;
      16'h0102: return 4'd8;
      default:  return DEV_UNKNOWN;
    endcase
  endfunction

  // Append one result to the current command; unused fields stay zero
  task automatic add_event(input logic [3:0] cls, input logic [1:0] warn,
                           input logic [7:0] data, input logic [11:0] addr,
                           input logic hi, input logic [63:0] s0);
    isc_result_t ev;
    ev = '0;
    ev.event_class  = cls;
    ev.warning_kind = warn;
    ev.data_value   = data;
    ev.mem_address  = addr;
    ev.high_half    = hi;
    ev.span_start   = s0;
    ev.span_end     = command_t1;
    batch[batch_len] = ev;
    batch_len++;
  endtask

  // Take one transfer; on the fourth of a command, decode and queue its results
  task automatic decode_transfer(input logic [7:0] hb, input logic [7:0] rb,
                                 input logic [63:0] t0, input logic [63:0] t1);
    logic [7:0] c0, c1, c2, c3, r0, r1, r2, r3;
    logic [63:0] s0;
    if (byte_slot == 2'd0) command_t0 = t0;
    if (byte_slot != 2'd3) begin
      host_seen[byte_slot]  = hb;
      reply_seen[byte_slot] = rb;
      byte_slot = byte_slot + 2'd1;
    end else begin
      byte_slot = 2'd0;
      {c0, c1, c2, c3} = {host_seen[0], host_seen[1], host_seen[2], hb};
      {r0, r1, r2, r3} = {reply_seen[0], reply_seen[1], reply_seen[2], rb};
      s0 = command_t0;
      command_t1 = t1;
      batch_len = 0;
      if (c0 == OP_PROG_EN && c1 == OP_PROG_EN2) begin
        add_event(EV_ENABLE, WARN_NONE, 8'h00, 12'h000, 1'b0, s0);
        if (r1 != OP_PROG_EN || r2 != OP_PROG_EN2 || r3 != c2)
          add_event(EV_WARNING, WARN_REPLY, 8'h00, 12'h000, 1'b0, s0);
      end else if (c0 == OP_PROG_EN && c1[7]) begin
        add_event(EV_ERASE, WARN_NONE, 8'h00, 12'h000, 1'b0, s0);
        if (r1 != OP_PROG_EN || !r2[7] || r3 != c2)
          add_event(EV_WARNING, WARN_REPLY, 8'h00, 12'h000, 1'b0, s0);
      end else if (c0 == OP_FUSE_RD && c1 == BYTE_ZERO && c2 == BYTE_ZERO) begin
        add_event(EV_FUSE, WARN_NONE, r3, 12'h000, 1'b0, s0);
      end else if (c0 == OP_LOCK_RD && c1 == OP_FUSE_SEL && c2 == BYTE_ZERO) begin
        add_event(EV_HFUSE, WARN_NONE, r3, 12'h000, 1'b0, s0);
      end else if (c0 == OP_FUSE_RD && c1 == OP_FUSE_SEL && c2 == BYTE_ZERO) begin
        add_event(EV_EFUSE, WARN_NONE, r3, 12'h000, 1'b0, s0);
      end else if (c0 == OP_SIG_RD && c2 == BYTE_ZERO) begin
        // Vendor byte: remember address echo and poll byte for the next reads
        add_event(EV_SIG0, WARN_NONE, r3, 12'h000, 1'b0, s0);
        batch[0].vendor_class = (r3 == VENDOR_MAIN) ? VND_MAIN :
                                (r3 == BYTE_ZERO) ? VND_LOCKED : VND_UNKNOWN;
        echo_addr  = c1;
        poll_first = c3;
        if (r1 != OP_SIG_RD || r2 != c1)
          add_event(EV_WARNING, WARN_REPLY, 8'h00, 12'h000, 1'b0, s0);
        if (r3 != VENDOR_MAIN)
          add_event(EV_WARNING, WARN_VENDOR, 8'h00, 12'h000, 1'b0, s0);
      end else if (c0 == OP_SIG_RD && c2 == SIG_IDX1) begin
        family_id = r3;
        add_event(EV_SIG1, WARN_NONE, r3, 12'h000, 1'b0, s0);
        poll_second = c3;
        device_t0   = s0;
        if (r1 != OP_SIG_RD || r2 != c1 || r0 != poll_first)
          add_event(EV_WARNING, WARN_REPLY, 8'h00, 12'h000, 1'b0, s0);
      end else if (c0 == OP_SIG_RD && c2 == SIG_IDX2) begin
        // Part byte closes the signature: name the device, then clear the polls
        add_event(EV_SIG2, WARN_NONE, r3, 12'h000, 1'b0, s0);
        add_event(EV_DEVICE, WARN_NONE, 8'h00, 12'h000, 1'b0, device_t0);
        batch[1].device_id = find_device(family_id, r3);
        if (r1 != OP_SIG_RD || r2 != echo_addr || r0 != poll_second)
          add_event(EV_WARNING, WARN_REPLY, 8'h00, 12'h000, 1'b0, s0);
        echo_addr   = 8'h00;
        poll_first  = 8'h00;
        poll_second = 8'h00;
      end else if (c0 == OP_LOCK_RD && c1 == BYTE_ZERO) begin
        add_event(EV_LOCK, WARN_NONE, r3, 12'h000, 1'b0, s0);
      end else if (c0 == OP_EE_RD && c1[7:6] == 2'b00) begin
        add_event(EV_EEPROM, WARN_NONE, r3, {3'b000, c1[0], c2}, 1'b0, s0);
      end else if ((c0 == OP_PROG_RDL || c0 == OP_PROG_RDH) && c1[7:4] == 4'h0) begin
        add_event(EV_READ_PROG, WARN_NONE, r3, {c1[3:0], c2}, c0[3], s0);
      end else if ((c0 == OP_LOAD_L || c0 == OP_LOAD_H) && c1[7:4] == 4'h0) begin
        add_event(EV_LOAD_PAGE, WARN_NONE, c3, {7'b0, c2[4:0]}, c0[3], s0);
      end else if (c0 == OP_WRITE_PG && c1[7:4] == 4'h0) begin
        add_event(EV_WRITE_PG, WARN_NONE, 8'h00, {5'b0, c1[3:0], c2[7:5]}, 1'b0, s0);
      end else begin
        add_event(EV_WARNING, WARN_UNKNOWN, 8'h00, 12'h000, 1'b0, s0);
        batch[0].command_word = {c0, c1, c2, c3};
        batch[0].reply_word   = {r0, r1, r2, r3};
      end
      batch[batch_len - 1].last_of_run = 1'b1;
      for (int i = 0; i < batch_len; i++) expected_events.push_back(batch[i]);
    end
  endtask

  // Compare accepted results, then predict from accepted transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_slot   = 2'd0;
      command_t0  = '0;
      command_t1  = '0;
      device_t0   = '0;
      echo_addr   = 8'h00;
      poll_first  = 8'h00;
      poll_second = 8'h00;
      family_id   = 8'h00;
      for (int i = 0; i < 3; i++) begin
        host_seen[i]  = 8'h00;
        reply_seen[i] = 8'h00;
      end
      expected_events.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result with nothing expected, class", out_ch.event_class, 0);
        end else begin
          head_event = expected_events.pop_front();
          compare_field("event_class", out_ch.event_class, head_event.event_class);
          compare_field("warning_kind", out_ch.warning_kind, head_event.warning_kind);
          compare_field("data_value", out_ch.data_value, head_event.data_value);
          compare_field("mem_address", out_ch.mem_address, head_event.mem_address);
          compare_field("high_half", out_ch.high_half, head_event.high_half);
          compare_field("vendor_class", out_ch.vendor_class, head_event.vendor_class);
          compare_field("device_id", out_ch.device_id, head_event.device_id);
          compare_field("command_word", out_ch.command_word, head_event.command_word);
          compare_field("reply_word", out_ch.reply_word, head_event.reply_word);
          compare_field("span_start", out_ch.span_start, head_event.span_start);
          compare_field("span_end", out_ch.span_end, head_event.span_end);
          compare_field("last_of_run", out_ch.last_of_run, head_event.last_of_run);
        end
      end
      if (in_ch.valid && in_ch.ready)
        decode_transfer(in_ch.host_byte, in_ch.target_byte,
                        in_ch.byte_start_time, in_ch.byte_end_time);
    end
    pending_events = expected_events.size();
  end

endmodule

>>> tb/sv/isp_spi_command_decoder_top_tb.sv
// Testbench top for the serial programming command decoder: clock, reset,
// transfer stimulus, receiver stalls and the verdict.
// Depends on isc_pkg, isc_if.sv, the decoder RTL and isp_command_checker.
`timescale 1ns / 1ps

module isp_spi_command_decoder_top_tb;
  import isc_pkg::*;

  typedef enum int {
    K_ENABLE, K_ERASE, K_FUSE, K_HFUSE, K_EFUSE, K_SIGS,
    K_LOCK, K_EEPROM, K_PROG_RD, K_LOAD, K_WRITE, K_NOISE
  } cmd_kind_e;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_events;
  int   transfers_sent;
  bit   steady_stretch;
  bit   held_long;
  bit   paused_mid;

  // Sample timeline and our view of the signature state
  logic [63:0] timeline;
  logic [7:0]  echo_mirror;
  logic [7:0]  poll0_mirror;
  logic [7:0]  poll1_mirror;

  isc_in_if  in_ch ();
  isc_out_if out_ch ();

  isp_spi_command_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  isp_command_checker decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_events (pending_events)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Idle cycles before a transfer: mostly none or short, a few long
  function automatic int idle_len();
    int pick;
    if (steady_stretch) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Flip one random bit now and then
  function automatic logic [31:0] maybe_flip(input logic [31:0] word, input int odds);
    int b;
    if ($urandom_range(1, odds) == 1) begin
      b = $urandom_range(0, 31);
      word[b] = ~word[b];
    end
    return word;
  endfunction

  // Offer one transfer and hold it until the decoder takes it
  task automatic send_transfer(input logic [7:0] hb, input logic [7:0] rb,
                               input logic [63:0] t0, input logic [63:0] t1);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.host_byte       <= hb;
    in_ch.target_byte     <= rb;
    in_ch.byte_start_time <= t0;
    in_ch.byte_end_time   <= t1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    transfers_sent++;
    @(negedge clk);
  endtask

  // Four transfers along the timeline, first byte most significant
  task automatic send_command(input logic [31:0] host_w, input logic [31:0] reply_w);
    logic [63:0] t0, t1;
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 15) == 0) timeline = {$urandom, $urandom};
      t0 = timeline + $urandom_range(0, 40);
      t1 = t0 + $urandom_range(8, 80);
      timeline = t1;
      send_transfer(host_w[8*i +: 8], reply_w[8*i +: 8], t0, t1);
    end
  endtask

  // Hold the input idle until every expected result has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_events != 0) @(negedge clk);
  endtask

  // One signature read with the echoes the decoder expects, sometimes broken
  task automatic send_signature_read(input logic [7:0] index, input logic [7:0] answer);
    logic [31:0] hw, rw;
    logic [7:0]  addr_b, poll_b;
    addr_b = 8'($urandom);
    poll_b = 8'($urandom);
    hw = {OP_SIG_RD, addr_b, index, poll_b};
    if (index == BYTE_ZERO) begin
      rw = {8'($urandom), OP_SIG_RD, addr_b, answer};
      echo_mirror  = addr_b;
      poll0_mirror = poll_b;
    end else if (index == SIG_IDX1) begin
      rw = {poll0_mirror, OP_SIG_RD, addr_b, answer};
      poll1_mirror = poll_b;
    end else begin
      rw = {poll1_mirror, OP_SIG_RD, echo_mirror, answer};
      echo_mirror  = 8'h00;
      poll0_mirror = 8'h00;
      poll1_mirror = 8'h00;
    end
    send_command(hw, maybe_flip(rw, 10));
  endtask

  // Vendor, family, part; occasionally with a read left out
  task automatic send_signature_run();
    int pick;
    logic [7:0] vendor, fam, part;
    pick = $urandom_range(0, 5);
    vendor = (pick == 0) ? BYTE_ZERO : (pick == 1) ? 8'($urandom) : VENDOR_MAIN;
    pick = $urandom_range(0, DEV_COUNT);
    if (pick == DEV_COUNT) begin
      fam  = 8'($urandom);
      part = 8'($urandom);
    end else begin
      fam  = DEV_FAMILY[pick];
      part = DEV_PART[pick];
    end
    if ($urandom_range(0, 7) != 0) send_signature_read(BYTE_ZERO, vendor);
    if ($urandom_range(0, 7) != 0) send_signature_read(SIG_IDX1, fam);
    send_signature_read(SIG_IDX2, part);
  endtask

  // Mostly well-formed commands with random operands, some noise and damage
  task automatic send_random_command();
    cmd_kind_e kind;
    logic [31:0] hw, rw;
    kind = cmd_kind_e'($urandom_range(0, K_NOISE));
    hw = $urandom;
    rw = $urandom;
    if (kind == K_SIGS) begin
      send_signature_run();
    end else begin
      case (kind)
        K_ENABLE: begin
          hw[31:16] = {OP_PROG_EN, OP_PROG_EN2};
          rw[23:0]  = {OP_PROG_EN, OP_PROG_EN2, hw[15:8]};
        end
        K_ERASE: begin
          hw[31:24] = OP_PROG_EN;
          hw[23]    = 1'b1;
          rw[23:16] = OP_PROG_EN;
          rw[15]    = 1'b1;
          rw[7:0]   = hw[15:8];
        end
        K_FUSE:    hw[31:8]  = {OP_FUSE_RD, BYTE_ZERO, BYTE_ZERO};
        K_HFUSE:   hw[31:8]  = {OP_LOCK_RD, OP_FUSE_SEL, BYTE_ZERO};
        K_EFUSE:   hw[31:8]  = {OP_FUSE_RD, OP_FUSE_SEL, BYTE_ZERO};
        K_LOCK:    hw[31:16] = {OP_LOCK_RD, BYTE_ZERO};
        K_EEPROM: begin
          hw[31:24] = OP_EE_RD;
          hw[23:22] = 2'b00;
        end
        K_PROG_RD: begin
          hw[31:24] = $urandom_range(0, 1) ? OP_PROG_RDH : OP_PROG_RDL;
          hw[23:20] = 4'h0;
        end
        K_LOAD: begin
          hw[31:24] = $urandom_range(0, 1) ? OP_LOAD_H : OP_LOAD_L;
          hw[23:20] = 4'h0;
        end
        K_WRITE: begin
          hw[31:24] = OP_WRITE_PG;
          hw[23:20] = 4'h0;
        end
        default: ;
      endcase
      send_command(maybe_flip(hw, 16), maybe_flip(rw, 8));
    end
  endtask

  // Receiver: random ready with short and long stalls, one very long hold-off
  initial begin : receiver
    int span;
    out_ch.ready = 1'b0;
    held_long    = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (!held_long && transfers_sent >= 150) begin
        held_long = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (90) @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (span) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Sender: reset, directed commands, random commands, drain, verdict
  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.host_byte       = 8'h00;
    in_ch.target_byte     = 8'h00;
    in_ch.byte_start_time = '0;
    in_ch.byte_end_time   = '0;
    transfers_sent = 0;
    steady_stretch = 1'b0;
    paused_mid     = 1'b0;
    timeline       = '0;
    echo_mirror    = 8'h00;
    poll0_mirror   = 8'h00;
    poll1_mirror   = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Enable with clean echo at sample zero; all-ones unknown command at the top
    send_transfer(OP_PROG_EN, BYTE_ZERO, '0, '0);
    send_transfer(OP_PROG_EN2, OP_PROG_EN, '0, '0);
    send_transfer(BYTE_ZERO, OP_PROG_EN2, '0, '0);
    send_transfer(BYTE_ZERO, BYTE_ZERO, '0, '0);
    for (int i = 3; i >= 0; i--)
      send_transfer(8'hFF, 8'hFF, '1, '1);
    // Enable with a bad echo
    send_command({OP_PROG_EN, OP_PROG_EN2, 8'h5A, 8'hC3}, 32'h0000_0000);
    // Clean signature run naming a known device
    send_command({OP_SIG_RD, 8'h00, BYTE_ZERO, 8'h11}, {8'h00, OP_SIG_RD, 8'h00, VENDOR_MAIN});
    send_command({OP_SIG_RD, 8'h00, SIG_IDX1, 8'h22}, {8'h11, OP_SIG_RD, 8'h00, 8'h93});
    send_command({OP_SIG_RD, 8'h00, SIG_IDX2, 8'h33}, {8'h22, OP_SIG_RD, 8'h00, 8'h0A});
    // Part byte alone: polls already cleared, family kept from the last run
    send_command({OP_SIG_RD, 8'h7F, SIG_IDX2, 8'h00}, {BYTE_ZERO, OP_SIG_RD, BYTE_ZERO, 8'h0A});
    // Vendor byte with a bad echo and a foreign vendor: three results
    send_command({OP_SIG_RD, 8'h55, BYTE_ZERO, 8'h77}, 32'h0000_0042);
    drain_results();

    while (transfers_sent < 280) begin
      steady_stretch = ($urandom_range(0, 4) == 0);
      if (!paused_mid && transfers_sent >= 230) begin
        paused_mid = 1'b1;
        drain_results();
      end
      send_random_command();
    end

    drain_results();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && pending_events == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
